/* rtl/core/dls_pkg.sv */
// Shared types, codes and result helpers for the display-list segmenter.
`timescale 1ns / 1ps

package dls_pkg;

   // Pending entry codes of the back end
   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_RUN  = 2'd1;
   localparam logic [1:0] MODE_CMD  = 2'd2;

   localparam logic [7:0] MAX_RUN = 8'd255;

   // Classified byte passed from the front end to the back end
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic        is_cmd;
      logic [15:0] address;
   } item_type;

   // One display-list entry as delivered on the result side
   typedef struct packed {
      logic [15:0] entry_address;
      logic [7:0]  byte_count;
      logic [7:0]  first_byte;
      logic [7:0]  second_byte;
      logic [7:0]  third_byte;
      logic [15:0] target_address;
      logic        has_target;
      logic        repeated;
      logic        final_result;
   } result_type;

   // Report a pending run or a truncated command
   function automatic result_type flush_entry(
      input logic [1:0]  mode,
      input logic [15:0] start,
      input logic [7:0]  opcode,
      input logic [7:0]  count,
      input logic [7:0]  operand
   );
      result_type r;
      r                = '0;
      r.entry_address  = start;
      r.byte_count     = count;
      r.first_byte     = opcode;
      if (mode == MODE_RUN) begin
         r.second_byte = (count == 8'd2 || count == 8'd3) ? opcode : 8'd0;
         r.third_byte  = (count == 8'd3) ? opcode : 8'd0;
         r.repeated    = (count > 8'd3);
      end else begin
         r.second_byte = (count == 8'd2) ? operand : 8'd0;
      end
      return r;
   endfunction

   // Report a complete three-byte command with its target
   function automatic result_type command_entry(
      input logic [15:0] start,
      input logic [7:0]  opcode,
      input logic [7:0]  operand,
      input logic [7:0]  high_byte
   );
      result_type r;
      r                = '0;
      r.entry_address  = start;
      r.byte_count     = 8'd3;
      r.first_byte     = opcode;
      r.second_byte    = operand;
      r.third_byte     = high_byte;
      r.target_address = {high_byte, operand};
      r.has_target     = 1'b1;
      return r;
   endfunction

endpackage

/* rtl/core/dls_queue.sv */
// Small register queue of classified bytes between front and back end.
`timescale 1ns / 1ps

module dls_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dls_pkg::item_type push_word,
   output logic              full,
   input  logic              pop,
   output dls_pkg::item_type head_word,
   output logic              head_valid
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   dls_pkg::item_type slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == DEPTH_CNT);
   assign head_valid = (count_ff != '0);
   assign head_word  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

/* rtl/core/dls_front.sv */
// Front end: byte acceptance, address numbering and command classification.
`timescale 1ns / 1ps

module dls_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last_byte,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_start_address,
   input  logic              queue_full,
   output logic              queue_push,
   output dls_pkg::item_type queue_word
);

   localparam logic [7:0] LO_MASK = 8'h0f;
   localparam logic [7:0] HI_MASK = 8'hf0;
   localparam logic [7:0] LO_CMD  = 8'h01;
   localparam logic [7:0] HI_CMD  = 8'h40;

   logic [15:0] start_ff, start_in;
   logic [15:0] addr_ff, addr_in;
   logic        accept;
   logic        csr_write;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign req_full   = queue_full;
   assign accept     = req_push && !queue_full;
   assign queue_push = accept;

   // Classify the byte and tag it with its address
   always_comb begin
      queue_word.data_byte = req_data_byte;
      queue_word.last_byte = req_last_byte;
      queue_word.is_cmd    = ((req_data_byte & LO_MASK) == LO_CMD) ||
                             ((req_data_byte & HI_MASK) == HI_CMD);
      queue_word.address   = addr_ff;
   end

   // Address counter: wraps at 16 bits, reloads after the last byte
   always_comb begin
      start_in = start_ff;
      addr_in  = addr_ff;
      if (csr_write) begin
         start_in = csr_start_address;
         addr_in  = csr_start_address;
      end else if (accept) begin
         addr_in = req_last_byte ? start_ff : addr_ff + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         addr_ff  <= '0;
      end else begin
         start_ff <= start_in;
         addr_ff  <= addr_in;
      end
   end

endmodule

/* rtl/core/dls_back.sv */
// Back end: entry segmentation state and the result output register.
`timescale 1ns / 1ps

module dls_back (
   input  logic                clock,
   input  logic                reset,
   input  dls_pkg::item_type   head_word,
   input  logic                head_valid,
   output logic                head_pop,
   output dls_pkg::result_type out_word,
   output logic                out_valid,
   input  logic                out_pop
);

   logic [1:0]  mode_ff, mode_in;
   logic [15:0] start_ff, start_in;
   logic [7:0]  opcode_ff, opcode_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  operand_ff, operand_in;
   logic        phase_ff, phase_in;
   logic        valid_ff, valid_in;
   dls_pkg::result_type out_ff, out_in;

   logic                flush_a, has_b, two, slot_free, advance, emit;
   logic [1:0]          mode2;
   logic [15:0]         start2;
   logic [7:0]          opcode2, count2, operand2;
   logic [7:0]          b;
   dls_pkg::result_type res_a, res_b, pick;

   assign out_word  = out_ff;
   assign out_valid = valid_ff;
   assign slot_free = !valid_ff || out_pop;
   assign advance   = head_valid && slot_free;

   // Step the pending entry with the head byte
   always_comb begin
      b        = head_word.data_byte;
      flush_a  = (mode_ff == dls_pkg::MODE_RUN) && (b != opcode_ff);
      res_a    = dls_pkg::flush_entry(mode_ff, start_ff, opcode_ff, count_ff, operand_ff);
      mode2    = flush_a ? dls_pkg::MODE_IDLE : mode_ff;
      start2   = start_ff;
      opcode2  = opcode_ff;
      count2   = count_ff;
      operand2 = operand_ff;
      has_b    = 1'b0;
      res_b    = '0;
      case (mode2)
         dls_pkg::MODE_IDLE: begin
            start2   = head_word.address;
            opcode2  = b;
            count2   = 8'd1;
            operand2 = 8'd0;
            mode2    = head_word.is_cmd ? dls_pkg::MODE_CMD : dls_pkg::MODE_RUN;
         end
         dls_pkg::MODE_RUN: begin
            count2 = count_ff + 8'd1;
         end
         dls_pkg::MODE_CMD: begin
            if (count_ff == 8'd1) begin
               operand2 = b;
               count2   = 8'd2;
            end else begin
               res_b = dls_pkg::command_entry(start_ff, opcode_ff, operand_ff, b);
               has_b = 1'b1;
               mode2 = dls_pkg::MODE_IDLE;
            end
         end
         default: begin
            mode2 = dls_pkg::MODE_IDLE;
         end
      endcase
      // Run cap, then end of region
      if ((mode2 == dls_pkg::MODE_RUN && count2 == dls_pkg::MAX_RUN) ||
          (head_word.last_byte && mode2 != dls_pkg::MODE_IDLE)) begin
         res_b = dls_pkg::flush_entry(mode2, start2, opcode2, count2, operand2);
         has_b = 1'b1;
         mode2 = dls_pkg::MODE_IDLE;
      end
      two = flush_a && has_b;
   end

   // Sequence one or two words per byte; a byte with two is popped with its second
   always_comb begin
      head_pop = 1'b0;
      phase_in = phase_ff;
      emit     = 1'b0;
      pick     = flush_a ? res_a : res_b;
      pick.final_result = 1'b1;
      if (advance) begin
         if (two && !phase_ff) begin
            pick              = res_a;
            pick.final_result = 1'b0;
            emit              = 1'b1;
            phase_in          = 1'b1;
         end else if (two) begin
            pick              = res_b;
            pick.final_result = 1'b1;
            emit              = 1'b1;
            head_pop          = 1'b1;
            phase_in          = 1'b0;
         end else begin
            emit     = flush_a || has_b;
            head_pop = 1'b1;
         end
      end
   end

   // Next values of state and output register
   always_comb begin
      mode_in    = mode_ff;
      start_in   = start_ff;
      opcode_in  = opcode_ff;
      count_in   = count_ff;
      operand_in = operand_ff;
      if (head_pop) begin
         mode_in    = mode2;
         start_in   = start2;
         opcode_in  = opcode2;
         count_in   = count2;
         operand_in = operand2;
      end
      out_in   = emit ? pick : out_ff;
      valid_in = emit ? 1'b1 : (out_pop ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= dls_pkg::MODE_IDLE;
         start_ff   <= '0;
         opcode_ff  <= '0;
         count_ff   <= '0;
         operand_ff <= '0;
         phase_ff   <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         start_ff   <= start_in;
         opcode_ff  <= opcode_in;
         count_ff   <= count_in;
         operand_ff <= operand_in;
         phase_ff   <= phase_in;
         valid_ff   <= valid_in;
      end
   end

   // Result payload, no reset needed
   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

/* rtl/core/display_list_segmenter_top.sv */
// Top level of the display-list segmenter.
`timescale 1ns / 1ps

// Takes one region byte per cycle on the req_ queue port while req_full is low
// and returns display-list entries on the rsp_ queue port, oldest first;
// rsp_final_result marks the last word caused by a byte. The front end numbers
// and classifies each byte and writes it into a QUEUE_DEPTH-entry queue; the back
// end consumes one queued byte per cycle, except a byte that both closes a run and
// ends the region, which yields two words and stays queued until both are issued.
// Sustained rate is one byte per cycle while rsp_pop keeps up. Writing
// csr_start_address also reloads the address counter; write it only while idle.

module display_list_segmenter_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [15:0] rsp_entry_address,
   output logic [7:0]  rsp_byte_count,
   output logic [7:0]  rsp_first_byte,
   output logic [7:0]  rsp_second_byte,
   output logic [7:0]  rsp_third_byte,
   output logic [15:0] rsp_target_address,
   output logic        rsp_has_target,
   output logic        rsp_repeated,
   output logic        rsp_final_result,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_start_address
);

   dls_pkg::item_type   push_word, head_word;
   dls_pkg::result_type out_word;
   logic                queue_full, queue_push, head_valid, head_pop, out_valid;

   dls_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_start_address (csr_start_address),
      .queue_full        (queue_full),
      .queue_push        (queue_push),
      .queue_word        (push_word)
   );

   dls_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_word  (push_word),
      .full       (queue_full),
      .pop        (head_pop),
      .head_word  (head_word),
      .head_valid (head_valid)
   );

   dls_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_word  (head_word),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .out_word   (out_word),
      .out_valid  (out_valid),
      .out_pop    (rsp_pop)
   );

   // Result ports
   assign rsp_empty          = !out_valid;
   assign rsp_entry_address  = out_word.entry_address;
   assign rsp_byte_count     = out_word.byte_count;
   assign rsp_first_byte     = out_word.first_byte;
   assign rsp_second_byte    = out_word.second_byte;
   assign rsp_third_byte     = out_word.third_byte;
   assign rsp_target_address = out_word.target_address;
   assign rsp_has_target     = out_word.has_target;
   assign rsp_repeated       = out_word.repeated;
   assign rsp_final_result   = out_word.final_result;

endmodule

/* rtl/core/dls_checker.sv */
// Port-level checks for the display-list segmenter, bound to its top level.
`timescale 1ns / 1ps

module dls_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [15:0] rsp_entry_address,
   input logic [7:0]  rsp_byte_count,
   input logic [7:0]  rsp_first_byte,
   input logic        rsp_has_target,
   input logic        rsp_repeated,
   input logic        rsp_final_result
);

   // Nothing to deliver right after reset
   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result word visible after reset");

   // A waiting word holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_entry_address) &&
         $stable(rsp_byte_count) && $stable(rsp_first_byte) &&
         $stable(rsp_final_result)))
      else $error("stalled result word changed");

   // A word with a target is a complete command
   a_target_count: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_has_target) |-> (rsp_byte_count == 8'd3 && !rsp_repeated))
      else $error("target on an entry that is not a full command");

   // Repeated runs are longer than three bytes; no entry is empty
   a_repeat_count: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_byte_count != 8'd0 &&
         (!rsp_repeated || rsp_byte_count > 8'd3)))
      else $error("byte count inconsistent with repeat flag");

endmodule

bind display_list_segmenter_top dls_checker u_dls_checker (.*);
